@@ hdl/vcsl_pkg.sv @@
// ----------------------------------------------------------------------------
// vcsl_pkg
// shared types, constants and the angle table of the command safety limiter
// ----------------------------------------------------------------------------
`default_nettype none

package vcsl_pkg;

	// cordic datapath widths and angle table length
	localparam int CORDIC_W = 33;
	localparam int ANGLE_W  = 24;
	localparam int ATAN_LEN = 24;

	// q1.14 one and the border nudge of 0.1
	localparam logic [14:0] STEER_ONE    = 15'd16384;
	localparam logic [10:0] BORDER_NUDGE = 11'd1638;

	// atan(2^-i) in degrees, q16
	localparam logic [21:0] ATAN_DEG [ATAN_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	typedef enum logic [1:0] {
		CFG_MASS   = 2'd0,
		CFG_TORQUE = 2'd1,
		CFG_RADIUS = 2'd2,
		CFG_STEER  = 2'd3
	} cfg_idx_t;

	// command fields and decided restrictions that ride beside the datapath
	typedef struct packed {
		logic signed [15:0] steer;
		logic [14:0]        throttle;
		logic [14:0]        brake;
		logic               left_act;
		logic               right_act;
		logic               brk_act;
		logic               border;
	} side_t;

endpackage

`default_nettype wire

@@ hdl/vcsl_cordic.sv @@
// ----------------------------------------------------------------------------
// vcsl_cordic
// pipelined cordic vectoring, one iteration per stage, angle in degrees q16
// ----------------------------------------------------------------------------
`default_nettype none

module vcsl_cordic #(
	parameter int ITER = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic signed [vcsl_pkg::CORDIC_W-1:0]   x_in,
	input  wire logic signed [vcsl_pkg::CORDIC_W-1:0]   y_in,
	output logic signed [vcsl_pkg::ANGLE_W-1:0]         z_out
);
	import vcsl_pkg::*;

	logic signed [CORDIC_W-1:0] x_s [ITER];
	logic signed [CORDIC_W-1:0] y_s [ITER];
	logic signed [ANGLE_W-1:0]  z_s [ITER];

	for (genvar i = 0; i < ITER; i++) begin : g_iter
		logic signed [CORDIC_W-1:0] x_p, y_p, xs, ys;
		logic signed [ANGLE_W-1:0]  z_p, a;

		if (i == 0) begin : g_first
			assign x_p = x_in;
			assign y_p = y_in;
			assign z_p = '0;
		end else begin : g_next
			assign x_p = x_s[i-1];
			assign y_p = y_s[i-1];
			assign z_p = z_s[i-1];
		end

		assign xs = x_p >>> i;
		assign ys = y_p >>> i;
		assign a  = $signed({2'b00, ATAN_DEG[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_p[CORDIC_W-1]) begin
					x_s[i] <= x_p + ys;
					y_s[i] <= y_p - xs;
					z_s[i] <= z_p + a;
				end else begin
					x_s[i] <= x_p - ys;
					y_s[i] <= y_p + xs;
					z_s[i] <= z_p - a;
				end
			end
		end
	end

	assign z_out = z_s[ITER-1];

endmodule

`default_nettype wire

@@ hdl/vcsl_div.sv @@
// ----------------------------------------------------------------------------
// vcsl_div
// pipelined restoring divider, one quotient bit per stage, tag rides along
// ----------------------------------------------------------------------------
`default_nettype none

module vcsl_div #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 15,
	parameter int QW    = 29,
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num_in,
	input  wire logic [DEN_W-1:0] den_in,
	input  wire logic [TAG_W-1:0] tag_in,
	output logic [QW-1:0]         quo_out,
	output logic [TAG_W-1:0]      tag_out
);
	// quotient must fit in QW bits
	localparam int WW = ((DEN_W + QW) > NUM_W) ? (DEN_W + QW) : NUM_W;

	logic [NUM_W-1:0] rem_s [QW];
	logic [DEN_W-1:0] den_s [QW];
	logic [QW-1:0]    quo_s [QW];
	logic [TAG_W-1:0] tag_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [NUM_W-1:0] rem_p;
		logic [DEN_W-1:0] den_p;
		logic [QW-1:0]    quo_p;
		logic [TAG_W-1:0] tag_p;
		logic [WW-1:0]    d_sh, diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_p = num_in;
			assign den_p = den_in;
			assign quo_p = '0;
			assign tag_p = tag_in;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign quo_p = quo_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign d_sh = WW'(den_p) << (QW - 1 - k);
		assign ge   = WW'(rem_p) >= d_sh;
		assign diff = WW'(rem_p) - d_sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[NUM_W-1:0] : rem_p;
				den_s[k] <= den_p;
				quo_s[k] <= quo_p | (QW'(ge) << (QW - 1 - k));
				tag_s[k] <= tag_p;
			end
		end
	end

	assign quo_out = quo_s[QW-1];
	assign tag_out = tag_s[QW-1];

endmodule

`default_nettype wire

@@ hdl/vehicle_command_safety_limiter_top.sv @@
// ----------------------------------------------------------------------------
// vehicle_command_safety_limiter_top
// restricts a driver command by lateral countersteer and longitudinal braking
// ----------------------------------------------------------------------------
// pipeline: capture, cordic stages, rounding stage, 29 divider stages, output register
// throughput: one word per cycle; the whole pipeline advances together
// and holds while the output word waits
// reset: arst_n clears all valid bits and loads the register reset values
`default_nettype none

module vehicle_command_safety_limiter_top #(
	parameter int ATAN_ITERATIONS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// steer_in, throttle_in, brake_in, left_lat_accel_max, right_lat_accel_max,
	// lon_accel_max, lon_accel_min, lateral_speed, longitudinal_speed, pad
	input  wire logic [143:0] s_tdata,
	// reverse_gear, lane_border
	input  wire logic [1:0]   s_tuser,
	// output stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// steer_out, throttle_out, brake_out, pad
	output logic [47:0]       m_tdata,
	// register writes
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [15:0]  cfg_wdata
);
	import vcsl_pkg::*;

	localparam int STEER_N_W = 29;
	localparam int STEER_Q_W = 29;
	localparam int BRK_N_W   = 46;
	localparam int BRK_D_W   = 23;
	localparam int BRK_Q_W   = 15;
	// stages after capture until the steer quotient shows
	localparam int STEER_LAT = ATAN_ITERATIONS + 1 + STEER_Q_W;
	// stages after capture until the brake quotient shows
	localparam int BRK_LAT   = 3 + BRK_Q_W;
	localparam int BRK_DLY   = STEER_LAT - BRK_LAT;

	// configuration registers
	logic [15:0] mass_q;
	logic [15:0] torque_q;
	logic [7:0]  radius_q;
	logic [14:0] steer_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q      <= 16'd1500;
			torque_q    <= 16'd6000;
			radius_q    <= 8'd35;
			steer_max_q <= 15'd17920;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_MASS:   mass_q      <= cfg_wdata;
				CFG_TORQUE: torque_q    <= cfg_wdata;
				CFG_RADIUS: radius_q    <= cfg_wdata[7:0];
				CFG_STEER:  steer_max_q <= cfg_wdata[14:0];
			endcase
		end
	end

	// zero torque and steer limit registers behave as one
	logic [14:0] steer_max_eff;
	logic [15:0] torque_eff;
	assign steer_max_eff = (steer_max_q == '0) ? 15'd1 : steer_max_q;
	assign torque_eff    = (torque_q == '0) ? 16'd1 : torque_q;

	// whole pipeline moves when the output register is free or being taken
	logic en;
	logic o_v_q;
	assign en       = !o_v_q || m_tready;
	assign s_tready = en;

	// input word unpacking
	logic signed [15:0] in_steer, in_left, in_right, in_lon_max, in_lon_min, in_lat, in_lon;
	logic [14:0]        in_throttle, in_brake;
	logic               in_rev, in_border;

	assign in_steer    = s_tdata[15:0];
	assign in_throttle = s_tdata[30:16];
	assign in_brake    = s_tdata[45:31];
	assign in_left     = s_tdata[61:46];
	assign in_right    = s_tdata[77:62];
	assign in_lon_max  = s_tdata[93:78];
	assign in_lon_min  = s_tdata[109:94];
	assign in_lat      = s_tdata[125:110];
	assign in_lon      = s_tdata[141:126];
	assign in_rev      = s_tuser[0];
	assign in_border   = s_tuser[1];

	// stage 1: capture and decide which restrictions apply
	logic               v_s1;
	side_t              side_s1;
	logic signed [15:0] lat_s1, lon_s1, lon_min_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.steer     <= in_steer;
			side_s1.throttle  <= in_throttle;
			side_s1.brake     <= in_brake;
			// left drift with no positive left margin
			side_s1.left_act  <= !in_rev && (in_left <= 0) && (in_lat < 0) && (in_lon != 0);
			// right drift with no positive right margin
			side_s1.right_act <= !in_rev && (in_right <= 0) && (in_lat > 0) && (in_lon != 0);
			// braking demanded when even the longitudinal maximum is negative
			side_s1.brk_act   <= !in_rev && (in_lon_max < 0);
			side_s1.border    <= in_border;
			lat_s1            <= in_lat;
			lon_s1            <= in_lon;
			lon_min_s1        <= in_lon_min;
		end
	end

	// cordic start vector: x = |lon| * 2^14, y = lat * sign(lon) * 2^14
	logic signed [16:0]         lon_e, lat_e, lon_abs, y_v;
	logic signed [CORDIC_W-1:0] x0, y0;
	logic signed [ANGLE_W-1:0]  z_cor;

	assign lon_e   = 17'(lon_s1);
	assign lat_e   = 17'(lat_s1);
	assign lon_abs = lon_e[16] ? -lon_e : lon_e;
	assign y_v     = lon_e[16] ? -lat_e : lat_e;
	assign x0      = $signed({{(CORDIC_W - 31){1'b0}}, lon_abs, 14'b0});
	assign y0      = $signed({{(CORDIC_W - 31){y_v[16]}}, y_v, 14'b0});

	vcsl_cordic #(
		.ITER (ATAN_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.en    (en),
		.x_in  (x0),
		.y_in  (y0),
		.z_out (z_cor)
	);

	// rounding stage: |angle|*64 + m/2, remember the sign of the target
	logic [STEER_N_W-1:0] snum_s;
	logic                 sneg_s;
	logic [ANGLE_W-1:0]   z_abs;

	assign z_abs = z_cor[ANGLE_W-1] ? ANGLE_W'(-z_cor) : ANGLE_W'(z_cor);

	always_ff @(posedge clk) begin
		if (en) begin
			snum_s <= STEER_N_W'({z_abs, 6'b0}) + STEER_N_W'(steer_max_eff >> 1);
			// target is minus the angle
			sneg_s <= !z_cor[ANGLE_W-1] && (z_cor != '0);
		end
	end

	logic [STEER_Q_W-1:0] squo;
	logic                 sneg_q;

	vcsl_div #(
		.NUM_W (STEER_N_W),
		.DEN_W (15),
		.QW    (STEER_Q_W),
		.TAG_W (1)
	) u_steer_div (
		.clk     (clk),
		.en      (en),
		.num_in  (snum_s),
		.den_in  (steer_max_eff),
		.tag_in  (sneg_s),
		.quo_out (squo),
		.tag_out (sneg_q)
	);

	// brake path: mass * |min accel| * radius * 64 over torque * 100
	logic [15:0]        acc_abs;
	logic [31:0]        p1_s2;
	logic [BRK_D_W-1:0] den_s2, den_s3, den_s4;
	logic [BRK_N_W-1:0] num_s3, bnum_s4;
	logic [36:0]        dsat_s3;
	logic               bsat_s4;
	logic [BRK_N_W-1:0] bnum_r;

	assign acc_abs = lon_min_s1[15] ? 16'(-lon_min_s1) : 16'(lon_min_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2  <= mass_q * acc_abs;
			den_s2 <= BRK_D_W'(torque_eff) * BRK_D_W'(100);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= {40'(p1_s2) * 40'(radius_q), 6'b0};
			den_s3  <= den_s2;
			// 16385 * den: a rounded numerator at or above this saturates
			dsat_s3 <= {den_s2, 14'b0} + 37'(den_s2);
		end
	end

	assign bnum_r = num_s3 + BRK_N_W'(den_s3 >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			bnum_s4 <= bnum_r;
			den_s4  <= den_s3;
			bsat_s4 <= bnum_r >= BRK_N_W'(dsat_s3);
		end
	end

	logic [BRK_Q_W-1:0] bquo;
	logic               bsat_q;
	logic [14:0]        bval;

	vcsl_div #(
		.NUM_W (BRK_N_W),
		.DEN_W (BRK_D_W),
		.QW    (BRK_Q_W),
		.TAG_W (1)
	) u_brake_div (
		.clk     (clk),
		.en      (en),
		.num_in  (bnum_s4),
		.den_in  (den_s4),
		.tag_in  (bsat_s4),
		.quo_out (bquo),
		.tag_out (bsat_q)
	);

	assign bval = bsat_q ? STEER_ONE : bquo;

	// brake value waits for the longer steer path
	logic [14:0] brk_s [BRK_DLY];

	for (genvar j = 0; j < BRK_DLY; j++) begin : g_brk_dly
		always_ff @(posedge clk) begin
			if (en) begin
				brk_s[j] <= (j == 0) ? bval : brk_s[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// side fields and valid bits travel beside the datapath
	side_t side_s [STEER_LAT];
	logic  v_s    [STEER_LAT];

	for (genvar j = 0; j < STEER_LAT; j++) begin : g_side_dly
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= (j == 0) ? side_s1 : side_s[(j == 0) ? 0 : j - 1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= (j == 0) ? v_s1 : v_s[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// final stage: apply countersteer and braking
	side_t              sd;
	logic signed [30:0] tgt, nud, steer_e, tl, tr, m1, m2, st_res;
	logic signed [30:0] pos_one, neg_one;
	logic [14:0]        thr_res, brk_res;

	assign sd      = side_s[STEER_LAT-1];
	assign tgt     = sneg_q ? -$signed({2'b00, squo}) : $signed({2'b00, squo});
	assign nud     = sd.border ? $signed(31'(BORDER_NUDGE)) : 31'sd0;
	assign steer_e = 31'(sd.steer);
	assign pos_one = $signed(31'(STEER_ONE));
	assign neg_one = -pos_one;
	assign tl      = tgt + nud;
	assign tr      = tgt - nud;
	assign m1      = (tl > steer_e) ? tl : steer_e;
	assign m2      = (tr < steer_e) ? tr : steer_e;

	always_comb begin
		priority if (sd.left_act) begin
			st_res = (m1 > pos_one) ? pos_one : m1;
		end else if (sd.right_act) begin
			st_res = (m2 < neg_one) ? neg_one : m2;
		end else begin
			st_res = steer_e;
		end
	end

	assign thr_res = sd.brk_act ? 15'd0 : sd.throttle;
	assign brk_res = sd.brk_act ? brk_s[BRK_DLY-1] : sd.brake;

	// output register
	logic [47:0] o_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (en) begin
			o_v_q <= v_s[STEER_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_data_q <= {2'b00, brk_res, thr_res, st_res[15:0]};
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata  = o_data_q;

endmodule

`default_nettype wire

@@ hdl/vcsl_checker.sv @@
// ----------------------------------------------------------------------------
// vcsl_checker
// port level checks of the command safety limiter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module vcsl_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [143:0] s_tdata,
	input wire logic [1:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [47:0]  m_tdata,
	input wire logic         cfg_we,
	input wire logic [1:0]   cfg_addr,
	input wire logic [15:0]  cfg_wdata
);

	// an empty output side never holds back input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a waiting output word holds the pipeline
	a_stall_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output blocked");

	// pad bits of the output word stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:46] == 2'b00))
		else $error("output pad bits set");

	// a stalled output word keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output word changed");

endmodule

bind vehicle_command_safety_limiter_top vcsl_checker u_vcsl_checker (.*);

`default_nettype wire

@@ tb/tb_vehicle_command_safety_limiter_top.sv @@
// ----------------------------------------------------------------------------
// tb_vehicle_command_safety_limiter_top
// self-checking bench: random and directed commands are streamed in, each
// accepted word is predicted by an independent cordic and brake model, and
// every output word is checked in order against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_vehicle_command_safety_limiter_top;
	import vcsl_pkg::*;

	localparam int ITER      = 16;
	localparam int LATENCY   = ITER + 31;
	localparam int MAX_CYCLE = 600000;

	// one driver command as the bench sees it
	typedef struct {
		logic signed [15:0] steer;
		logic [14:0]        throttle;
		logic [14:0]        brake;
		logic               reverse;
		logic signed [15:0] left_max;
		logic signed [15:0] right_max;
		logic signed [15:0] lon_max;
		logic signed [15:0] lon_min;
		logic signed [15:0] lat;
		logic signed [15:0] lon;
		logic               border;
	} command_t;

	// limiter prediction and in-order result checker
	class limiter_scoreboard;
		logic [47:0]   pending_words[$];
		int            mismatches;
		longint        mass, torque, radius, steer_max;
		longint        atan_q16[24];

		function new();
			atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
				4, 2, 1, 0};
			mismatches = 0;
			mass = 1500; torque = 6000; radius = 35; steer_max = 17920;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				CFG_MASS:   mass = val;
				CFG_TORQUE: torque = val;
				CFG_RADIUS: radius = val[7:0];
				CFG_STEER:  steer_max = val[14:0];
			endcase
		endfunction

		// countersteer target in q1.14 from the drift direction
		function longint countersteer(longint lat, longint lon);
			longint x, y, z, xs, ys, q, m, n, r;
			x = (lon < 0 ? -lon : lon) * 16384;
			y = (lon < 0 ? -lat : lat) * 16384;
			z = 0;
			for (int i = 0; i < ITER; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + atan_q16[i];
				end else begin
					x = x - ys; y = y + xs; z = z - atan_q16[i];
				end
			end
			q = -z * 64;
			m = steer_max != 0 ? steer_max : 1;
			n = q < 0 ? -q : q;
			r = (n + m / 2) / m;
			return q < 0 ? -r : r;
		endfunction

		function void note(logic [143:0] d, logic [1:0] u);
			longint steer, lat, lon, t, lmin;
			longint unsigned num, den, b;
			logic [14:0] thr, brk;
			steer = $signed(d[15:0]);
			thr   = d[30:16];
			brk   = d[45:31];
			lat   = $signed(d[125:110]);
			lon   = $signed(d[141:126]);
			if (!u[0]) begin
				if ($signed(d[61:46]) <= 0 && lat < 0 && lon != 0) begin
					t = countersteer(lat, lon) + (u[1] ? 1638 : 0);
					if (t > steer) steer = t;
					if (steer > 16384) steer = 16384;
				end
				if ($signed(d[77:62]) <= 0 && lat > 0 && lon != 0) begin
					t = countersteer(lat, lon) - (u[1] ? 1638 : 0);
					if (t < steer) steer = t;
					if (steer < -16384) steer = -16384;
				end
				if ($signed(d[93:78]) < 0) begin
					lmin = $signed(d[109:94]);
					num = longint'(mass) * (lmin < 0 ? -lmin : lmin) * radius * 64;
					den = (torque != 0 ? torque : 1) * 100;
					b = (num + den / 2) / den;
					thr = '0;
					brk = b > 16384 ? 15'd16384 : b[14:0];
				end
			end
			pending_words.push_back({2'b00, brk, thr, steer[15:0]});
		endfunction

		function void check(logic [47:0] got);
			logic [47:0] want;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word %h", got);
				return;
			end
			want = pending_words.pop_front();
			if (got[15:0] !== want[15:0] || got[30:16] !== want[30:16]
					|| got[45:31] !== want[45:31]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch steer %0d/%0d throttle %0d/%0d brake %0d/%0d (exp/act)",
						$signed(want[15:0]), $signed(got[15:0]), want[30:16], got[30:16],
						want[45:31], got[45:31]);
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// steer, throttle, brake, left max, right max, lon max, lon min, lat, lon, pad
	logic [143:0] s_tdata = '0;
	// reverse_gear, lane_border
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// steer_out, throttle_out, brake_out, pad
	logic [47:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_addr = '0;
	logic [15:0]  cfg_wdata = '0;

	limiter_scoreboard sb = new();
	bit  no_idle = 1'b0;   // long stretch with both sides always ready
	int  cycles = 0;

	vehicle_command_safety_limiter_top #(.ATAN_ITERATIONS(ITER)) u_top (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata
	);

	always #2 clk = ~clk;

	// watch both handshakes on the edge, values seen are the pre-edge ones
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note(s_tdata, s_tuser);
		if (m_tvalid && m_tready)
			sb.check(m_tdata);
	end

	// output back-pressure
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= no_idle || ($urandom_range(99) >= 23);
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("tb: failure");
			$finish;
		end
	end

	// drive one word and hold it until the block takes it
	task automatic send(input command_t c);
		while (!no_idle && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, c.lon, c.lat, c.lon_min, c.lon_max, c.right_max, c.left_max,
			c.brake, c.throttle, c.steer};
		s_tuser  <= {c.border, c.reverse};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every prediction to be met
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] mass, torque, radius, smax);
		logic [15:0] v[4];
		v = '{mass, torque, radius, smax};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= cfg_idx_t'(i);
			cfg_wdata <= v[i];
			sb.set_reg(cfg_idx_t'(i), v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_q88();
		case ($urandom_range(5))
			0:       return 16'sd0;
			1:       return $signed(16'($urandom_range(0, 512)) - 16'd256);
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	function automatic command_t rand_command();
		command_t c;
		c.steer     = ($urandom_range(9) == 0) ? $signed(16'($urandom()))
			: $signed(16'($urandom_range(0, 32768)) - 16'd16384);
		c.throttle  = ($urandom_range(9) == 0) ? 15'($urandom()) : 15'($urandom_range(16384));
		c.brake     = ($urandom_range(9) == 0) ? 15'($urandom()) : 15'($urandom_range(16384));
		c.reverse   = ($urandom_range(9) == 0);
		c.left_max  = $urandom_range(1) ? -$signed(16'($urandom_range(32767))) : rand_q88();
		c.right_max = $urandom_range(1) ? -$signed(16'($urandom_range(32767))) : rand_q88();
		c.lon_max   = rand_q88();
		c.lon_min   = rand_q88();
		c.lat       = rand_q88();
		c.lon       = rand_q88();
		c.border    = 1'($urandom_range(1));
		return c;
	endfunction

	function automatic command_t mk(input int st, thr, brk, rev, lm, rm, lx, ln, la, lo, bd);
		command_t c;
		c.steer = 16'(st); c.throttle = 15'(thr); c.brake = 15'(brk); c.reverse = 1'(rev);
		c.left_max = 16'(lm); c.right_max = 16'(rm); c.lon_max = 16'(lx);
		c.lon_min = 16'(ln); c.lat = 16'(la); c.lon = 16'(lo); c.border = 1'(bd);
		return c;
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= n / 4 && i < n / 2);
			send(rand_command());
			// one pause three quarters into the phase until everything is back
			if (i == n * 3 / 4)
				drain();
		end
		no_idle = 1'b0;
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset register values
		send(mk(16384, 16384, 16384, 0, 100, 100, 100, 0, 0, 100, 0));
		send(mk(-16384, 0, 0, 0, 100, 100, 100, 0, 0, 100, 0));
		send(mk(0, 16384, 16384, 1, -5, -5, -5, -32768, -300, 800, 1));
		// left drift, with and without the border nudge
		send(mk(-16384, 1000, 0, 0, 0, 100, 10, 0, -300, 800, 0));
		send(mk(-16384, 1000, 0, 0, -1, 100, 10, 0, -300, 800, 1));
		send(mk(16384, 1000, 0, 0, -32768, 100, 10, 0, -32768, 1, 1));
		// right drift
		send(mk(16384, 1000, 0, 0, 100, 0, 10, 0, 300, 800, 0));
		send(mk(16384, 1000, 0, 0, 100, -1, 10, 0, 300, -800, 1));
		send(mk(-16384, 1000, 0, 0, 100, -32768, 10, 0, 32767, 1, 1));
		// zero speeds: no countersteer
		send(mk(500, 100, 100, 0, -10, -10, 10, 0, -300, 0, 1));
		send(mk(500, 100, 100, 0, -10, -10, 10, 0, 0, 800, 1));
		// braking: saturation, zero, positive min, max negative
		send(mk(0, 16384, 0, 0, 10, 10, -1, -32768, 0, 100, 0));
		send(mk(0, 16384, 0, 0, 10, 10, -32768, 0, 0, 100, 0));
		send(mk(0, 16384, 0, 0, 10, 10, -256, 256, 0, 100, 0));
		send(mk(0, 16384, 0, 0, 10, 10, -256, -100, 0, 100, 0));
		// out of range fields pass through unless a drift limit applies to the steer
		send(mk(-32768, 32767, 32767, 0, 10, 10, 10, 0, 0, 100, 0));
		send(mk(32767, 32767, 32767, 0, -1, -1, 32767, 0, -32768, -32768, 1));
		random_phase(400);

		set_regs(16'hFFFF, 16'hFFFF, 16'd255, 16'd23040);
		random_phase(400);

		// zero registers, divisors treated as one
		set_regs(16'd0, 16'd0, 16'd0, 16'd0);
		random_phase(200);

		set_regs(16'd1, 16'd1, 16'd1, 16'd1);
		random_phase(200);

		set_regs(16'd900, 16'd12000, 16'd30, 16'd8000);
		random_phase(400);

		if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
